/* rtl/rrh_pkg.sv */
// Shared constants, register codes and types for the ray/rectangle hit test
`timescale 1ns / 1ps
`default_nettype none
package rrh_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int EXT_W  = 31;

  typedef enum logic [2:0] {
    REG_LENGTH = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_SEP    = 3'd2,
    REG_COS    = 3'd3,
    REG_SIN    = 3'd4
  } reg_idx_t;

  localparam logic [EXT_W-1:0]         RST_LENGTH = 31'd1677722;
  localparam logic [EXT_W-1:0]         RST_WIDTH  = 31'd1677722;
  localparam logic [EXT_W-1:0]         RST_SEP    = 31'd16777216;
  localparam logic signed [DATA_W-1:0] RST_COS    = 32'sd1073741824;
  localparam logic signed [DATA_W-1:0] RST_SIN    = 32'sd0;

  typedef struct packed {
    logic in_rect;
    logic par;
  } axis_res_t;

endpackage
`default_nettype wire

/* rtl/ray_rectangle_hit_test_top.sv */
// Top level of the ray/rectangle hit test: register file and pipeline
// Usage:
//   Input channel (in_valid/in_ready) takes one word per cycle: a track
//   direction in Q2.30 and a start point on the first plate in Q8.24.
//   Result channel (out_valid/out_ready) returns one word per input word,
//   in order: out_hit and out_parallel_track.
//   The word passes seven register stages, two projection stages and
//   five bound-test stages per axis, the first loaded at the accepting
//   edge.
//   Throughput is one word per cycle; every stage holds one word and is
//   set by the multiplier stages, each at most 33 by 33 bits.
//   The whole pipeline advances as one: it moves whenever the output
//   register is empty or being taken. When the receiver stalls, every
//   stage holds and in_ready drops; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits and loads the
//   register defaults: 0.1 m plate, 1.0 m separation, zero tilt.
//   Registers are written over the APB-style port at byte address 4*i;
//   write them only while the pipeline is empty.
//   A direction with zero normal component reports out_parallel_track
//   and no hit.
`timescale 1ns / 1ps
`default_nettype none
module ray_rectangle_hit_test_top import rrh_pkg::*; (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  signed [31:0]  in_dir_x,
  input  wire  signed [31:0]  in_dir_y,
  input  wire  signed [31:0]  in_dir_z,
  input  wire  signed [31:0]  in_offset_x,
  input  wire  signed [31:0]  in_offset_y,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic                out_hit,
  output logic                out_parallel_track,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [ADDR_W-1:0]   paddr,
  input  wire  [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [EXT_W-1:0]         length_r, width_r, sep_r;
  logic signed [DATA_W-1:0] cos_r, sin_r;
  reg_idx_t                 idx;
  logic                     wr_en;
  logic                     en;

  logic               pv;
  logic signed [64:0] n, px, py;
  logic signed [31:0] offx, offy;
  logic               vx, vy;
  axis_res_t          rx, ry;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // register file; writes beyond the list fall through the default arm
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= RST_LENGTH;
      width_r  <= RST_WIDTH;
      sep_r    <= RST_SEP;
      cos_r    <= RST_COS;
      sin_r    <= RST_SIN;
    end else if (wr_en) begin
      unique case (idx)
        REG_LENGTH: length_r <= pwdata[EXT_W-1:0];
        REG_WIDTH:  width_r  <= pwdata[EXT_W-1:0];
        REG_SEP:    sep_r    <= pwdata[EXT_W-1:0];
        REG_COS:    cos_r    <= pwdata;
        REG_SIN:    sin_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LENGTH: prdata = {1'b0, length_r};
      REG_WIDTH:  prdata = {1'b0, width_r};
      REG_SEP:    prdata = {1'b0, sep_r};
      REG_COS:    prdata = cos_r;
      REG_SIN:    prdata = sin_r;
      default:    prdata = '0;
    endcase
  end

  // advance when the output register is empty or drained this cycle
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  rrh_proj u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_i      (in_valid),
    .dir_x    (in_dir_x),
    .dir_y    (in_dir_y),
    .dir_z    (in_dir_z),
    .offset_x (in_offset_x),
    .offset_y (in_offset_y),
    .tilt_cos (cos_r),
    .tilt_sin (sin_r),
    .v_o      (pv),
    .n_o      (n),
    .px_o     (px),
    .py_o     (py),
    .offx_o   (offx),
    .offy_o   (offy)
  );

  rrh_axis u_axis_x (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (pv),
    .p_i   (px),
    .off_i (offx),
    .n_i   (n),
    .sep   (sep_r),
    .ext   (length_r),
    .v_o   (vx),
    .res_o (rx)
  );

  rrh_axis u_axis_y (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (pv),
    .p_i   (py),
    .off_i (offy),
    .n_i   (n),
    .sep   (sep_r),
    .ext   (width_r),
    .v_o   (vy),
    .res_o (ry)
  );

  // both axes carry the same word in lockstep
  assign out_valid          = vx & vy;
  assign out_hit            = rx.in_rect & ry.in_rect & ~ry.par;
  assign out_parallel_track = rx.par;

endmodule
`default_nettype wire

/* rtl/rrh_proj.sv */
// Projection stages: tilt products, normal component and in-plane direction
`timescale 1ns / 1ps
`default_nettype none
module rrh_proj import rrh_pkg::*; (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  wire                      v_i,
  input  wire  signed [31:0]       dir_x,
  input  wire  signed [31:0]       dir_y,
  input  wire  signed [31:0]       dir_z,
  input  wire  signed [31:0]       offset_x,
  input  wire  signed [31:0]       offset_y,
  input  wire  signed [DATA_W-1:0] tilt_cos,
  input  wire  signed [DATA_W-1:0] tilt_sin,
  output logic                     v_o,
  output logic signed [64:0]       n_o,
  output logic signed [64:0]       px_o,
  output logic signed [64:0]       py_o,
  output logic signed [31:0]       offx_o,
  output logic signed [31:0]       offy_o
);

  logic               v1_r, v2_r;
  logic signed [63:0] cdz_r, sdy_r, cdy_r, sdz_r;
  logic signed [31:0] dx_r, ox1_r, oy1_r, ox2_r, oy2_r;
  logic signed [64:0] n_r, py_r, px_r;
  logic signed [64:0] n_nxt, py_nxt, px_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    n_nxt  = 65'(cdz_r) - 65'(sdy_r);
    py_nxt = 65'(cdy_r) + 65'(sdz_r);
    px_nxt = $signed({{3{dx_r[31]}}, dx_r, 30'b0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cdz_r <= tilt_cos * dir_z;
      sdy_r <= tilt_sin * dir_y;
      cdy_r <= tilt_cos * dir_y;
      sdz_r <= tilt_sin * dir_z;
      dx_r  <= dir_x;
      ox1_r <= offset_x;
      oy1_r <= offset_y;
      n_r   <= n_nxt;
      py_r  <= py_nxt;
      px_r  <= px_nxt;
      ox2_r <= ox1_r;
      oy2_r <= oy1_r;
    end
  end

  assign v_o    = v2_r;
  assign n_o    = n_r;
  assign px_o   = px_r;
  assign py_o   = py_r;
  assign offx_o = ox2_r;
  assign offy_o = oy2_r;

endmodule
`default_nettype wire

/* rtl/rrh_axis.sv */
// Bound test along one plate axis: 2*|sep*p + off*n| <= extent*|n|
`timescale 1ns / 1ps
`default_nettype none
module rrh_axis import rrh_pkg::*; (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 v_i,
  input  wire  signed [64:0]  p_i,
  input  wire  signed [31:0]  off_i,
  input  wire  signed [64:0]  n_i,
  input  wire  [EXT_W-1:0]    sep,
  input  wire  [EXT_W-1:0]    ext,
  output logic                v_o,
  output axis_res_t           res_o
);

  logic               v3_r, v4_r, v5_r, v6_r, v7_r;
  logic               nz3_r, nz4_r, nz5_r, nz6_r, nz7_r;
  logic signed [31:0] sep_s;
  logic signed [32:0] p_lo, p_hi, n_lo, n_hi;
  logic signed [64:0] sp_lo_r, sp_hi_r, on_lo_r, on_hi_r;
  logic        [63:0] absn_nxt, absn_r;
  logic signed [64:0] nneg;
  logic signed [97:0] a_nxt, b_nxt, a_r, b_r, s_r, sneg;
  logic        [62:0] el_r, eh_r;
  logic        [95:0] rhs5_r, rhs6_r;
  logic        [96:0] lhs_r;
  logic               in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v3_r <= v_i;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_comb begin
    sep_s    = $signed({1'b0, sep});
    p_lo     = $signed({1'b0, p_i[31:0]});
    p_hi     = p_i[64:32];
    n_lo     = $signed({1'b0, n_i[31:0]});
    n_hi     = n_i[64:32];
    nneg     = -n_i;
    absn_nxt = n_i[64] ? nneg[63:0] : n_i[63:0];
    a_nxt    = $signed({sp_hi_r, 32'b0}) + 98'(sp_lo_r);
    b_nxt    = $signed({on_hi_r, 32'b0}) + 98'(on_lo_r);
    sneg     = -s_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // split the wide operands into a low 32-bit and a high 33-bit half
      sp_lo_r <= sep_s * p_lo;
      sp_hi_r <= sep_s * p_hi;
      on_lo_r <= off_i * n_lo;
      on_hi_r <= off_i * n_hi;
      absn_r  <= absn_nxt;
      nz3_r   <= (n_i == 65'sd0);
      // partial sums and extent products
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      el_r    <= 63'(ext) * 63'(absn_r[31:0]);
      eh_r    <= 63'(ext) * 63'(absn_r[63:32]);
      nz4_r   <= nz3_r;
      // join
      s_r     <= a_r + b_r;
      rhs5_r  <= {1'b0, eh_r, 32'b0} + 96'(el_r);
      nz5_r   <= nz4_r;
      // magnitude, doubled
      lhs_r   <= s_r[97] ? {sneg[95:0], 1'b0} : {s_r[95:0], 1'b0};
      rhs6_r  <= rhs5_r;
      nz6_r   <= nz5_r;
      // compare
      in_r    <= (lhs_r <= {1'b0, rhs6_r});
      nz7_r   <= nz6_r;
    end
  end

  assign v_o           = v7_r;
  assign res_o.in_rect = in_r;
  assign res_o.par     = nz7_r;

endmodule
`default_nettype wire

/* rtl/rrh_checker.sv */
// Port-level checks for the hit test top level and their bind
`timescale 1ns / 1ps
`default_nettype none
module rrh_checker (
  input wire clk,
  input wire rst_n,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire out_hit,
  input wire out_parallel_track
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit)
      && $stable(out_parallel_track))
    else $error("result word changed while stalled");

  a_par_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parallel_track |-> !out_hit)
    else $error("parallel track reported as hit");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output register");

endmodule

bind ray_rectangle_hit_test_top rrh_checker u_rrh_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_hit            (out_hit),
  .out_parallel_track (out_parallel_track)
);
`default_nettype wire
